FILE: hdl/assert_macros.svh
// Assertion macros shared by the converter RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/y2rgb_pkg.sv
// Package: types, coefficients and pipeline constants of the YCbCr to RGB converter.
`timescale 1ns / 1ps

package y2rgb_pkg;

    // pipeline geometry: seven lane stages plus the output register
    localparam int NUM_STG   = 8;
    localparam int NUM_LANES = 4;

    // 4:2:0 coefficients, 16.16 fixed point
    localparam logic signed [17:0] K_LUM   = 18'sd76309;
    localparam logic signed [17:0] K_R_CR  = 18'sd104597;
    localparam logic signed [15:0] K_G_CB  = 16'sd25675;
    localparam logic signed [16:0] K_G_CR  = 17'sd53279;
    localparam logic signed [18:0] K_B_CB  = 19'sd132201;

    // 4:2:2 coefficients, scaled by 10000
    localparam logic [13:0] K_DR_CR = 14'd15938;
    localparam logic [14:0] K_DB_CB = 15'd20238;
    localparam logic [13:0] K_DY    = 14'd11644;
    localparam logic [14:0] K_DG_Y  = 15'd19837;
    localparam logic [12:0] K_DG_R  = 13'd5094;
    localparam logic [10:0] K_DG_B  = 11'd1942;
    localparam logic [21:0] OFF_DR  = 22'd2221300;
    localparam logic [21:0] OFF_DB  = 22'd2771300;
    localparam logic [18:0] OFF_DG  = 19'd311710;

    // divide by 10000: q = (v * DIV_RECIP) >> DIV_SHIFT, exact for v < 2^22
    localparam logic [23:0] DIV_RECIP = 24'd13743896;
    localparam int          DIV_SHIFT = 37;
    // quotients at or above 256 start here
    localparam logic [22:0] DIV_SAT   = 23'd2560000;

    typedef struct packed {
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
    } src_item_t;

    typedef struct packed {
        logic [7:0] red_top_left;
        logic [7:0] green_top_left;
        logic [7:0] blue_top_left;
        logic [7:0] red_top_right;
        logic [7:0] green_top_right;
        logic [7:0] blue_top_right;
        logic [7:0] red_bottom_left;
        logic [7:0] green_bottom_left;
        logic [7:0] blue_bottom_left;
        logic [7:0] red_bottom_right;
        logic [7:0] green_bottom_right;
        logic [7:0] blue_bottom_right;
    } rgb_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // one lane's finished pixel under both formulas
    typedef struct packed {
        pixel_t tab;
        pixel_t dec;
    } lane_out_t;

    // chroma products shared by all lanes
    typedef struct packed {
        logic signed [24:0] r_tab;
        logic signed [22:0] g_cb;
        logic signed [23:0] g_cr;
        logic signed [25:0] b_tab;
        logic        [21:0] r_dec;
        logic        [22:0] b_dec;
    } chroma_terms_t;

    // per-stage load enables and the format of the item entering the output register
    typedef struct packed {
        logic [NUM_STG-1:0] load;
        logic               mode;
    } pipe_ctrl_t;

endpackage

FILE: hdl/y2rgb_chroma.sv
// Shared chroma multiplier stage feeding all luma lanes.
`timescale 1ns / 1ps

module y2rgb_chroma (
    input  logic                     clk,
    input  y2rgb_pkg::pipe_ctrl_t    ctrl,
    input  logic [7:0]               chroma_blue,
    input  logic [7:0]               chroma_red,
    output y2rgb_pkg::chroma_terms_t terms
);
    import y2rgb_pkg::*;

    logic signed [8:0]  dcb;
    logic signed [8:0]  dcr;
    logic signed [26:0] r_tab_full;
    logic signed [24:0] g_cb_full;
    logic signed [25:0] g_cr_full;
    logic signed [27:0] b_tab_full;
    logic        [21:0] r_dec_full;
    logic        [22:0] b_dec_full;
    chroma_terms_t      terms_next;
    chroma_terms_t      terms_reg;

    // centered chroma for the 16.16 path
    assign dcb = $signed({1'b0, chroma_blue} - 9'd128);
    assign dcr = $signed({1'b0, chroma_red} - 9'd128);

    assign r_tab_full = dcr * K_R_CR;
    assign g_cb_full  = dcb * K_G_CB;
    assign g_cr_full  = dcr * K_G_CR;
    assign b_tab_full = dcb * K_B_CB;
    assign r_dec_full = chroma_red * K_DR_CR;
    assign b_dec_full = chroma_blue * K_DB_CB;

    always_comb
    begin
        terms_next.r_tab = r_tab_full[24:0];
        terms_next.g_cb  = g_cb_full[22:0];
        terms_next.g_cr  = g_cr_full[23:0];
        terms_next.b_tab = b_tab_full[25:0];
        terms_next.r_dec = r_dec_full;
        terms_next.b_dec = b_dec_full;
    end

    // stage 0 product register
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

FILE: hdl/y2rgb_lane.sv
// One luma lane: both conversion formulas for a single pixel, seven stages deep.
`timescale 1ns / 1ps

module y2rgb_lane (
    input  logic                     clk,
    input  y2rgb_pkg::pipe_ctrl_t    ctrl,
    input  y2rgb_pkg::chroma_terms_t chroma,
    input  logic [7:0]               luma,
    output y2rgb_pkg::lane_out_t     result
);
    import y2rgb_pkg::*;

    // floor shift by 16 and clip to a byte
    function automatic logic [7:0] clip_tab(input logic signed [26:0] s);
        logic signed [10:0] sh;
        sh = s[26:16];
        if (sh < 11'sd0)
            return 8'd0;
        else if (sh > 11'sd255)
            return 8'd255;
        else
            return sh[7:0];
    endfunction

    // quotient by 10000 with saturation flags
    function automatic logic [7:0] quot_sat(input logic neg, input logic hi,
                                            input logic [45:0] prod);
        if (neg)
            return 8'd0;
        else if (hi)
            return 8'd255;
        else
            return prod[DIV_SHIFT+7:DIV_SHIFT];
    endfunction

    // stage 0: luma products
    logic signed [8:0]  dy;
    logic signed [26:0] lum_full;
    logic signed [25:0] lum_s0_reg;
    logic        [21:0] ydr_next;
    logic        [21:0] ydr_s0_reg;
    logic        [22:0] ydg_next;
    logic        [22:0] ydg_s0_reg;

    assign dy       = $signed({1'b0, luma} - 9'd16);
    assign lum_full = dy * K_LUM;
    assign ydr_next = luma * K_DY;
    assign ydg_next = luma * K_DG_Y;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            lum_s0_reg <= lum_full[25:0];
            ydr_s0_reg <= ydr_next;
            ydg_s0_reg <= ydg_next;
        end
    end

    // stage 1: channel sums
    logic signed [26:0] rtab_next, gtab_next, btab_next;
    logic signed [26:0] rtab_s1_reg, gtab_s1_reg, btab_s1_reg;
    logic        [23:0] rdec_next, bdec_next;
    logic        [23:0] rdec_s1_reg, bdec_s1_reg;
    logic        [22:0] ydg_s1_reg;

    always_comb
    begin
        rtab_next = 27'(lum_s0_reg) + 27'($signed(chroma.r_tab));
        gtab_next = 27'(lum_s0_reg) - 27'($signed(chroma.g_cb))
                  - 27'($signed(chroma.g_cr));
        btab_next = 27'(lum_s0_reg) + 27'($signed(chroma.b_tab));
        rdec_next = {2'b0, chroma.r_dec} + {2'b0, ydr_s0_reg} - 24'(OFF_DR);
        bdec_next = {1'b0, chroma.b_dec} + {2'b0, ydr_s0_reg} - 24'(OFF_DB);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            rtab_s1_reg <= rtab_next;
            gtab_s1_reg <= gtab_next;
            btab_s1_reg <= btab_next;
            rdec_s1_reg <= rdec_next;
            bdec_s1_reg <= bdec_next;
            ydg_s1_reg  <= ydg_s0_reg;
        end
    end

    // stage 2: 16.16 clip; red/blue reciprocal multiply
    pixel_t       tab_next;
    pixel_t       tab_s2_reg;
    logic         rneg_next, rhi_next, bneg_next, bhi_next;
    logic         rneg_s2_reg, rhi_s2_reg, bneg_s2_reg, bhi_s2_reg;
    logic [45:0]  rprod_next, bprod_next;
    logic [45:0]  rprod_s2_reg, bprod_s2_reg;
    logic [22:0]  ydg_s2_reg;

    always_comb
    begin
        tab_next.red   = clip_tab(rtab_s1_reg);
        tab_next.green = clip_tab(gtab_s1_reg);
        tab_next.blue  = clip_tab(btab_s1_reg);
        rneg_next  = rdec_s1_reg[23];
        rhi_next   = !rdec_s1_reg[23] && (rdec_s1_reg[22:0] >= DIV_SAT);
        rprod_next = rdec_s1_reg[21:0] * DIV_RECIP;
        bneg_next  = bdec_s1_reg[23];
        bhi_next   = !bdec_s1_reg[23] && (bdec_s1_reg[22:0] >= DIV_SAT);
        bprod_next = bdec_s1_reg[21:0] * DIV_RECIP;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            tab_s2_reg   <= tab_next;
            rneg_s2_reg  <= rneg_next;
            rhi_s2_reg   <= rhi_next;
            rprod_s2_reg <= rprod_next;
            bneg_s2_reg  <= bneg_next;
            bhi_s2_reg   <= bhi_next;
            bprod_s2_reg <= bprod_next;
            ydg_s2_reg   <= ydg_s1_reg;
        end
    end

    // stage 3: clipped red and blue
    pixel_t      tab_s3_reg;
    logic [7:0]  r_s3_reg, b_s3_reg;
    logic [22:0] ydg_s3_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            tab_s3_reg <= tab_s2_reg;
            r_s3_reg   <= quot_sat(rneg_s2_reg, rhi_s2_reg, rprod_s2_reg);
            b_s3_reg   <= quot_sat(bneg_s2_reg, bhi_s2_reg, bprod_s2_reg);
            ydg_s3_reg <= ydg_s2_reg;
        end
    end

    // stage 4: green sum from luma and clipped red/blue
    logic [20:0] gr_prod;
    logic [18:0] gb_prod;
    logic [23:0] gs_next;
    pixel_t      tab_s4_reg;
    logic [7:0]  r_s4_reg, b_s4_reg;
    logic [23:0] gs_s4_reg;

    assign gr_prod = r_s3_reg * K_DG_R;
    assign gb_prod = b_s3_reg * K_DG_B;
    assign gs_next = {1'b0, ydg_s3_reg} - 24'(OFF_DG) - 24'(gr_prod) - 24'(gb_prod);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            tab_s4_reg <= tab_s3_reg;
            r_s4_reg   <= r_s3_reg;
            b_s4_reg   <= b_s3_reg;
            gs_s4_reg  <= gs_next;
        end
    end

    // stage 5: green reciprocal multiply
    logic        gneg_next, ghi_next;
    logic [45:0] gprod_next;
    pixel_t      tab_s5_reg;
    logic [7:0]  r_s5_reg, b_s5_reg;
    logic        gneg_s5_reg, ghi_s5_reg;
    logic [45:0] gprod_s5_reg;

    assign gneg_next  = gs_s4_reg[23];
    assign ghi_next   = !gs_s4_reg[23] && (gs_s4_reg[22:0] >= DIV_SAT);
    assign gprod_next = gs_s4_reg[21:0] * DIV_RECIP;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            tab_s5_reg   <= tab_s4_reg;
            r_s5_reg     <= r_s4_reg;
            b_s5_reg     <= b_s4_reg;
            gneg_s5_reg  <= gneg_next;
            ghi_s5_reg   <= ghi_next;
            gprod_s5_reg <= gprod_next;
        end
    end

    // stage 6: lane result
    lane_out_t res_next;
    lane_out_t res_s6_reg;

    always_comb
    begin
        res_next.tab       = tab_s5_reg;
        res_next.dec.red   = r_s5_reg;
        res_next.dec.green = quot_sat(gneg_s5_reg, ghi_s5_reg, gprod_s5_reg);
        res_next.dec.blue  = b_s5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
        begin
            res_s6_reg <= res_next;
        end
    end

    assign result = res_s6_reg;

endmodule

FILE: hdl/y2rgb_merge.sv
// Merge stage: picks each lane's formula by format and builds the output item.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module y2rgb_merge (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  y2rgb_pkg::pipe_ctrl_t                            ctrl,
    input  y2rgb_pkg::lane_out_t [y2rgb_pkg::NUM_LANES-1:0] lane_res,
    output y2rgb_pkg::rgb_item_t                             item
);
    import y2rgb_pkg::*;

    rgb_item_t item_next;
    rgb_item_t item_reg;
    logic      mode_out_reg;

    // 4:2:2 uses the decimal result for the top pair and zeroes the bottom
    always_comb
    begin
        item_next = '0;
        if (ctrl.mode)
        begin
            item_next.red_top_left    = lane_res[0].dec.red;
            item_next.green_top_left  = lane_res[0].dec.green;
            item_next.blue_top_left   = lane_res[0].dec.blue;
            item_next.red_top_right   = lane_res[1].dec.red;
            item_next.green_top_right = lane_res[1].dec.green;
            item_next.blue_top_right  = lane_res[1].dec.blue;
        end
        else
        begin
            item_next.red_top_left       = lane_res[0].tab.red;
            item_next.green_top_left     = lane_res[0].tab.green;
            item_next.blue_top_left      = lane_res[0].tab.blue;
            item_next.red_top_right      = lane_res[1].tab.red;
            item_next.green_top_right    = lane_res[1].tab.green;
            item_next.blue_top_right     = lane_res[1].tab.blue;
            item_next.red_bottom_left    = lane_res[2].tab.red;
            item_next.green_bottom_left  = lane_res[2].tab.green;
            item_next.blue_bottom_left   = lane_res[2].tab.blue;
            item_next.red_bottom_right   = lane_res[3].tab.red;
            item_next.green_bottom_right = lane_res[3].tab.green;
            item_next.blue_bottom_right  = lane_res[3].tab.blue;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ctrl.load[NUM_STG-1])
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_out_reg <= 1'b0;
        end
        else if (ctrl.load[NUM_STG-1])
        begin
            mode_out_reg <= ctrl.mode;
        end
    end

    assign item = item_reg;

    // bottom pixels of a 4:2:2 item are black
    `ASSERT_IMPLY(a_bottom_zero, clk, rst_n, mode_out_reg, (item_reg.red_bottom_left == 8'd0) && (item_reg.green_bottom_left == 8'd0) && (item_reg.blue_bottom_left == 8'd0) && (item_reg.red_bottom_right == 8'd0) && (item_reg.green_bottom_right == 8'd0) && (item_reg.blue_bottom_right == 8'd0))

endmodule

FILE: hdl/ycbcr_to_rgb_subsampled_converter_top.sv
// Top level of the YCbCr to RGB converter: pipeline control, lanes and merge.
//
//   channel   direction  handshake               payload
//   src       in         src_valid / src_stall   src_data  (y2rgb_pkg::src_item_t)
//   rgb       out        rgb_valid / rgb_stall   rgb_data  (y2rgb_pkg::rgb_item_t)
//   mode      in         mode_write              mode_data (format_mode, 1 bit)
//
// One item per clock sustained while rgb is not stalled; rgb_valid rises once the item
// has passed the seven lane registers, the first loaded at the accepting edge (two reciprocal
// multiplies for the divide by 10000 in series), and then the output register.
// Four lanes convert the four luma samples in parallel against shared chroma products.
// rst_n clears the stage valid bits and format_mode; no clearing pass.
// A stall on rgb holds the output; empty stages behind it keep filling,
// and src_stall rises only when every stage holds an item.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ycbcr_to_rgb_subsampled_converter_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  y2rgb_pkg::src_item_t  src_data,
    output logic                  rgb_valid,
    input  logic                  rgb_stall,
    output y2rgb_pkg::rgb_item_t  rgb_data,
    input  logic                  mode_write,
    input  logic                  mode_data
);
    import y2rgb_pkg::*;

    logic                 fmt_reg;
    logic [NUM_STG-1:0]   stage_v_reg;
    logic [NUM_STG-1:0]   stage_v_next;
    logic [NUM_STG-1:0]   adv;
    logic [NUM_STG-2:0]   mode_reg;
    logic [NUM_STG-2:0]   mode_next;
    pipe_ctrl_t           ctrl;
    chroma_terms_t        chroma;
    logic [7:0]           luma [NUM_LANES];
    lane_out_t [NUM_LANES-1:0] lane_res;

    // format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= 1'b0;
        end
        else if (mode_write)
        begin
            fmt_reg <= mode_data;
        end
    end

    // a stage advances when it is empty or the stage after it advances; the last when rgb is not stalled
    always_comb
    begin
        adv[NUM_STG-1] = !stage_v_reg[NUM_STG-1] || !rgb_stall;
        for (int k = NUM_STG - 2; k >= 0; k--)
        begin
            adv[k] = !stage_v_reg[k] || adv[k+1];
        end
    end

    assign stage_v_next = (adv & {stage_v_reg[NUM_STG-2:0], src_valid})
                        | (~adv & stage_v_reg);
    assign mode_next    = (adv[NUM_STG-2:0] & {mode_reg[NUM_STG-3:0], fmt_reg})
                        | (~adv[NUM_STG-2:0] & mode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= '0;
            mode_reg    <= '0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
            mode_reg    <= mode_next;
        end
    end

    assign ctrl.load = adv;
    assign ctrl.mode = mode_reg[NUM_STG-2];

    assign src_stall = !adv[0];
    assign rgb_valid = stage_v_reg[NUM_STG-1];

    // lane inputs
    assign luma[0] = src_data.luma_top_left;
    assign luma[1] = src_data.luma_top_right;
    assign luma[2] = src_data.luma_bottom_left;
    assign luma[3] = src_data.luma_bottom_right;

    y2rgb_chroma u_chroma (
        .clk         (clk),
        .ctrl        (ctrl),
        .chroma_blue (src_data.chroma_blue),
        .chroma_red  (src_data.chroma_red),
        .terms       (chroma)
    );

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        y2rgb_lane u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .chroma (chroma),
            .luma   (luma[g]),
            .result (lane_res[g])
        );
    end

    y2rgb_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .lane_res (lane_res),
        .item     (rgb_data)
    );

    // input is held off only with the whole pipe full
    `ASSERT_IMPLY(a_stall_full, clk, rst_n, src_stall, &stage_v_reg)
    // an accepted item always lands in the first stage
    `ASSERT_NEXT(a_accept_lands, clk, rst_n, src_valid && !src_stall, stage_v_reg[0])
    // an item ready at the last lane stage fills an empty output register
    `ASSERT_NEXT(a_out_fill, clk, rst_n, stage_v_reg[NUM_STG-2] && !rgb_valid, rgb_valid)

endmodule

FILE: test/tb_top.sv
// Testbench for the YCbCr to RGB converter: pixel predictor and random idling.
`timescale 1ns / 1ps

module tb_top;
    import y2rgb_pkg::*;

    localparam logic MODE_420      = 1'b0;
    localparam logic MODE_422      = 1'b1;
    localparam int   RESET_CYCLES  = 12;
    localparam int   DRAIN_CYCLES  = 16;
    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   RANDOM_PHASES = 5;
    localparam int   PHASE_ITEMS   = 166;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    src_item_t src_data;
    logic      rgb_valid;
    logic      rgb_stall;
    rgb_item_t rgb_data;
    logic      mode_write;
    logic      mode_data;

    src_item_t pending_blocks_q[$];
    rgb_item_t predicted_rgb_q[$];
    logic      format_sel;
    logic      idle_en;
    int        gap_odds;
    int        src_gap;
    int        sink_gap;
    logic      src_fire;
    int        fail_count;
    int        cycle_count;

    string rgb_names [12] = '{
        "red_top_left", "green_top_left", "blue_top_left",
        "red_top_right", "green_top_right", "blue_top_right",
        "red_bottom_left", "green_bottom_left", "blue_bottom_left",
        "red_bottom_right", "green_bottom_right", "blue_bottom_right"
    };

    ycbcr_to_rgb_subsampled_converter_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .rgb_data   (rgb_data),
        .mode_write (mode_write),
        .mode_data  (mode_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // saturate to one byte
    function automatic logic [7:0] clamp_byte(longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // 4:2:0 path: 16.16 fixed point, flooring shift
    function automatic pixel_t table_pixel(longint y, longint cb, longint cr);
        pixel_t p;
        longint lum;
        lum     = 76309 * (y - 16);
        p.red   = clamp_byte((lum + 104597 * (cr - 128)) >>> 16);
        p.green = clamp_byte((lum - 25675 * (cb - 128) - 53279 * (cr - 128)) >>> 16);
        p.blue  = clamp_byte((lum + 132201 * (cb - 128)) >>> 16);
        return p;
    endfunction

    // truncating divide by 10000; negative sums give zero
    function automatic logic [7:0] scale_down(longint v);
        if (v < 0)
            return 8'd0;
        return clamp_byte(v / 10000);
    endfunction

    // 4:2:2 path: green works from the clipped red and blue
    function automatic pixel_t decimal_pixel(longint y, longint cb, longint cr);
        pixel_t p;
        longint r;
        longint b;
        p.red   = scale_down(15938 * cr - 2221300 + 11644 * y);
        p.blue  = scale_down(20238 * cb - 2771300 + 11644 * y);
        r       = p.red;
        b       = p.blue;
        p.green = scale_down(19837 * y - 311710 - 5094 * r - 1942 * b);
        return p;
    endfunction

    function automatic rgb_item_t convert_block(src_item_t s, logic mode);
        rgb_item_t o;
        if (mode == MODE_420)
            o = {table_pixel(s.luma_top_left, s.chroma_blue, s.chroma_red),
                 table_pixel(s.luma_top_right, s.chroma_blue, s.chroma_red),
                 table_pixel(s.luma_bottom_left, s.chroma_blue, s.chroma_red),
                 table_pixel(s.luma_bottom_right, s.chroma_blue, s.chroma_red)};
        else
            o = {decimal_pixel(s.luma_top_left, s.chroma_blue, s.chroma_red),
                 decimal_pixel(s.luma_top_right, s.chroma_blue, s.chroma_red),
                 48'd0};
        return o;
    endfunction

    task automatic compare_rgb(rgb_item_t want, rgb_item_t got);
        logic [95:0] w;
        logic [95:0] g;
        w = want;
        g = got;
        for (int k = 0; k < 12; k++)
        begin
            if (w[95 - 8 * k -: 8] !== g[95 - 8 * k -: 8])
            begin
                $error("%s: expected %0d, actual %0d",
                       rgb_names[k], w[95 - 8 * k -: 8], g[95 - 8 * k -: 8]);
                fail_count++;
            end
        end
    endtask

    // result check, then prediction of each accepted item
    always @(posedge clk)
    begin
        src_fire <= rst_n && src_valid && !src_stall;
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (predicted_rgb_q.size() == 0)
            begin
                $error("rgb item arrived with none expected");
                fail_count++;
            end
            else
                compare_rgb(predicted_rgb_q.pop_front(), rgb_data);
        end
        if (rst_n && src_valid && !src_stall)
            predicted_rgb_q.push_back(convert_block(src_data, format_sel));
    end

    // source driver: hold while stalled, random idle bursts
    always @(negedge clk)
    begin
        if (rst_n && (!src_valid || src_fire))
        begin
            if (src_gap > 0)
            begin
                src_valid <= 1'b0;
                src_gap   <= src_gap - 1;
            end
            else if (idle_en && $urandom_range(0, gap_odds) == 0)
            begin
                src_valid <= 1'b0;
                src_gap   <= $urandom_range(0, 5);
            end
            else if (pending_blocks_q.size() != 0)
            begin
                src_data  <= pending_blocks_q.pop_front();
                src_valid <= 1'b1;
            end
            else
                src_valid <= 1'b0;
        end
    end

    // sink: random stall bursts
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            rgb_stall <= 1'b1;
            sink_gap  <= sink_gap - 1;
        end
        else if (idle_en && $urandom_range(0, gap_odds) == 0)
        begin
            rgb_stall <= 1'b1;
            sink_gap  <= $urandom_range(0, 5);
        end
        else
            rgb_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[ycbcr_to_rgb_subsampled_converter_top] ERROR");
            $finish;
        end
    end

    task automatic push_block(int cb, int cr, int ytl, int ytr, int ybl, int ybr);
        src_item_t s;
        s.chroma_blue       = 8'(cb);
        s.chroma_red        = 8'(cr);
        s.luma_top_left     = 8'(ytl);
        s.luma_top_right    = 8'(ytr);
        s.luma_bottom_left  = 8'(ybl);
        s.luma_bottom_right = 8'(ybr);
        pending_blocks_q.push_back(s);
    endtask

    // skewed toward the range ends and the studio-range limits
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 24));
            3: return 8'($urandom_range(230, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic set_format(logic m);
        @(negedge clk);
        mode_write <= 1'b1;
        mode_data  <= m;
        format_sel  = m;
        @(negedge clk);
        mode_write <= 1'b0;
    endtask

    // sender holds off until every predicted result is back; checked at the
    // rising edge so the driver's last update is already visible
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_blocks_q.size() != 0 || src_valid || predicted_rgb_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic push_directed(logic m);
        // neutral and extreme chroma across the luma range; the first three blocks' bottom rows differ per mode
        push_block(128, 128, 16, 235, m ? 7 : 0, m ? 200 : 255);
        push_block(0, 0, 0, 0, m ? 255 : 0, m ? 255 : 0);
        push_block(255, 255, 255, 255, m ? 0 : 255, m ? 0 : 255);
        push_block(0, 255, 16, 235, 128, 81);
        push_block(255, 0, 16, 235, 128, 41);
        push_block(0, 0, 255, 255, 255, 255);
        push_block(255, 255, 0, 0, 0, 0);
        push_block(90, 240, 81, 82, 145, 41);
        push_block(54, 34, 145, 144, 210, 170);
        push_block(128, 128, 0, 255, 1, 254);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        src_data    = '0;
        rgb_stall   = 1'b0;
        mode_write  = 1'b0;
        mode_data   = 1'b0;
        format_sel  = MODE_420;
        idle_en     = 1'b0;
        gap_odds    = 7;
        src_gap     = 0;
        sink_gap    = 0;
        src_fire    = 1'b0;
        fail_count  = 0;
        cycle_count = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed items in both formats
        idle_en = 1'b1;
        set_format(MODE_420);
        push_directed(MODE_420);
        wait_drained();
        set_format(MODE_422);
        push_directed(MODE_422);
        wait_drained();

        // random phases, alternating format; the last one runs without idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_format(p[0] ? MODE_422 : MODE_420);
            idle_en  = (p != RANDOM_PHASES - 1);
            gap_odds = $urandom_range(2, 12);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_block(pick_sample(), pick_sample(), pick_sample(),
                           pick_sample(), pick_sample(), pick_sample());
            wait_drained();
        end

        if (fail_count == 0)
            $display("[ycbcr_to_rgb_subsampled_converter_top] OK");
        else
            $display("[ycbcr_to_rgb_subsampled_converter_top] ERROR");
        $finish;
    end

endmodule
